>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk with synchronous reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define GRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define GRA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/gra_pkg.sv
package gra_pkg;

  localparam int SLOTS   = 1024;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int COORD_W = 13;
  localparam int AREA_W  = 2 * COORD_W;
  localparam int SIZE_W  = 14;
  localparam int ALIGN_W = 9;
  localparam int PAD_W   = 4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  localparam logic [7:0] REG_ATLAS_W = 8'd0;
  localparam logic [7:0] REG_ATLAS_H = 8'd1;
  localparam logic [7:0] REG_PAD     = 8'd2;
  localparam logic [7:0] REG_ALIGN   = 8'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } rect_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

>>> rtl/guillotine_rect_allocator_unit.sv
// Guillotine atlas allocator, best area fit over an ordered free list.
// Input words: in_tuser is the command (0 allocate, 1 restart), in_tdata
// carries the requested size. Each word gives one result word on out_.
// Allocate: both sides go through an iterative align unit, then the free
// list, a chain of SLOTS cells, rotates once past the head cell for the
// best-fit search and once more to remove the chosen entry and append
// leftovers. The two chain passes set the time of an allocate; a restart
// goes straight to the result state. One word is in work at a time.
// A new word is accepted while the last result still waits on out_; the
// block holds each finished result until the output register is free
// (empty or out_tready) and only then returns to accept the next word.
// Reset seeds the list with one free rectangle of 4096 x 4096, zeroes
// the placement count and loads the register defaults. cfg_ writes are
// always accepted; atlas size takes effect on the next restart.
`include "assert_macros.svh"
module guillotine_rect_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // req_width[12:0], req_height[25:13], zero fill
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pos_x[11:0], pos_y[23:12], placed_total[39:24]
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int S  = gra_pkg::SLOTS;
  localparam int IW = gra_pkg::IDX_W;
  localparam int NW = gra_pkg::CNT_W;
  localparam int CW = gra_pkg::COORD_W;
  localparam int RW = gra_pkg::AREA_W;
  localparam int ZW = gra_pkg::SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ALIGN, S_SCAN, S_EVAL, S_SPLIT, S_PASS2, S_DONE
  } state_t;

  state_t                       state_r;
  logic [CW-1:0]                atlas_w_r, atlas_h_r;
  logic [gra_pkg::PAD_W-1:0]    pad_r;
  logic [gra_pkg::ALIGN_W-1:0]  align_r;
  logic [NW-1:0]                count_r;
  logic [15:0]                  alloc_r;
  logic [IW-1:0]                k_r;
  logic [ZW-1:0]                aw_r, ah_r;
  gra_pkg::rect_t               pipe_r;
  logic                         pipe_v_r;
  logic [IW-1:0]                pipe_idx_r;
  logic                         found_r;
  logic [RW-1:0]                best_area_r;
  gra_pkg::rect_t               best_r;
  logic [IW-1:0]                best_idx_r;
  gra_pkg::rect_t               lo1_r, lo2_r;
  logic                         push1_r, push2_r;
  logic [NW-1:0]                cdel_r;
  logic [1:0]                   res_st_r;
  logic [11:0]                  res_x_r, res_y_r;
  logic [15:0]                  res_tot_r;
  logic                         out_v_r;
  logic [1:0]                   out_st_r;
  logic [11:0]                  out_x_r, out_y_r;
  logic [15:0]                  out_tot_r;

  gra_pkg::rect_t               cell_q [S];
  gra_pkg::rect_t               insert;
  gra_pkg::rect_t               seed;
  logic                         shift;
  logic                         seed_load;
  logic                         in_acc;
  logic                         align_go;
  logic                         aw_done, ah_done;
  logic [ZW-1:0]                aw_res, ah_res;
  logic [ZW-1:0]                pad2;
  logic [RW-1:0]                area;
  logic                         fit;
  logic [CW-1:0]                ew, eh;
  logic                         wide;
  gra_pkg::rect_t               l1, l2;
  logic                         l1_ok, l2_ok, any_left;
  logic [NW-1:0]                cdel;
  logic                         p1, p2;
  logic [NW-1:0]                kx;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign align_go  = in_acc && !in_tuser;

  assign pad2 = ZW'({pad_r, 1'b0});

  gra_align u_align_w (
    .clk(clk), .rst_n(rst_n), .start(align_go),
    .size_in(ZW'(in_tdata[12:0]) + pad2), .align_in(align_r),
    .done(aw_done), .size_out(aw_res)
  );

  gra_align u_align_h (
    .clk(clk), .rst_n(rst_n), .start(align_go),
    .size_in(ZW'(in_tdata[25:13]) + pad2), .align_in(align_r),
    .done(ah_done), .size_out(ah_res)
  );

  assign seed_load = !rst_n || (in_acc && in_tuser);
  always_comb begin
    seed.x = '0;
    seed.y = '0;
    if (!rst_n) begin
      seed.w = CW'(4096);
      seed.h = CW'(4096);
    end else begin
      seed.w = atlas_w_r;
      seed.h = atlas_h_r;
    end
  end

  assign shift = (state_r == S_SCAN) || (state_r == S_PASS2);
  assign kx    = NW'(k_r);

  always_comb begin
    insert = cell_q[0];
    if (state_r == S_PASS2) begin
      if (k_r < best_idx_r) begin
        insert = cell_q[0];
      end else if (kx < cdel_r) begin
        insert = cell_q[1];
      end else if (push1_r && kx == cdel_r) begin
        insert = lo1_r;
      end else if (push2_r && kx == cdel_r + NW'(push1_r)) begin
        insert = lo2_r;
      end
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_chain
    gra_pkg::cell_ctl_t ctl;
    gra_pkg::rect_t     nxt_in;
    assign ctl.shift = shift;
    assign ctl.load  = (i == 0) ? seed_load : 1'b0;
    if (i == S - 1) begin : g_tail
      assign nxt_in = insert;
    end else begin : g_mid
      assign nxt_in = cell_q[i+1];
    end
    gra_cell u_cell (
      .clk(clk), .ctl(ctl), .shift_in(nxt_in), .load_val(seed), .q(cell_q[i])
    );
  end

  assign area = RW'(pipe_r.w) * RW'(pipe_r.h);
  assign fit  = pipe_v_r && (aw_r <= ZW'(pipe_r.w)) && (ah_r <= ZW'(pipe_r.h));

  assign ew       = best_r.w - aw_r[CW-1:0];
  assign eh       = best_r.h - ah_r[CW-1:0];
  assign wide     = ew > eh;
  assign l1.x     = best_r.x + aw_r[CW-1:0];
  assign l1.y     = best_r.y;
  assign l1.w     = ew;
  assign l1.h     = wide ? best_r.h : ah_r[CW-1:0];
  assign l2.x     = best_r.x;
  assign l2.y     = best_r.y + ah_r[CW-1:0];
  assign l2.w     = wide ? aw_r[CW-1:0] : best_r.w;
  assign l2.h     = eh;
  assign any_left = (ew != '0) || (eh != '0);
  assign l1_ok    = any_left && (l1.w != '0) && (l1.h != '0);
  assign l2_ok    = any_left && (l2.w != '0) && (l2.h != '0);
  assign cdel     = count_r - NW'(1);
  assign p1       = l1_ok && (cdel < NW'(S));
  assign p2       = l2_ok && ((cdel + NW'(p1)) < NW'(S));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      atlas_w_r <= CW'(4096);
      atlas_h_r <= CW'(4096);
      pad_r     <= '0;
      align_r   <= gra_pkg::ALIGN_W'(1);
      count_r   <= NW'(1);
      alloc_r   <= '0;
      k_r       <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          gra_pkg::REG_ATLAS_W: atlas_w_r <= cfg_data;
          gra_pkg::REG_ATLAS_H: atlas_h_r <= cfg_data;
          gra_pkg::REG_PAD:     pad_r     <= cfg_data[gra_pkg::PAD_W-1:0];
          gra_pkg::REG_ALIGN:   align_r   <= cfg_data[gra_pkg::ALIGN_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && (!out_v_r || out_tready)) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          k_r <= '0;
          if (in_acc) begin
            if (in_tuser) begin
              count_r   <= NW'((atlas_w_r != '0) && (atlas_h_r != '0));
              alloc_r   <= '0;
              res_st_r  <= gra_pkg::ST_OK;
              res_x_r   <= '0;
              res_y_r   <= '0;
              res_tot_r <= '0;
              state_r   <= S_DONE;
            end else begin
              state_r <= S_ALIGN;
            end
          end
        end
        S_ALIGN: begin
          if (aw_done && ah_done) begin
            aw_r     <= aw_res;
            ah_r     <= ah_res;
            found_r  <= 1'b0;
            pipe_v_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN, S_EVAL: begin
          if (fit && (!found_r || area < best_area_r)) begin
            found_r     <= 1'b1;
            best_area_r <= area;
            best_r      <= pipe_r;
            best_idx_r  <= pipe_idx_r;
          end
          pipe_r     <= cell_q[0];
          pipe_idx_r <= k_r;
          pipe_v_r   <= (state_r == S_SCAN) && (kx < count_r);
          if (state_r == S_SCAN) begin
            k_r <= k_r + IW'(1);
            if (k_r == IW'(S - 1)) begin
              state_r <= S_EVAL;
            end
          end else begin
            state_r <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          k_r <= '0;
          if (!found_r) begin
            res_st_r  <= gra_pkg::ST_NOFIT;
            res_x_r   <= '0;
            res_y_r   <= '0;
            res_tot_r <= alloc_r;
            state_r   <= S_DONE;
          end else begin
            lo1_r     <= l1;
            lo2_r     <= l2;
            push1_r   <= p1;
            push2_r   <= p2;
            cdel_r    <= cdel;
            res_st_r  <= ((l1_ok && !p1) || (l2_ok && !p2)) ?
                         gra_pkg::ST_DROPPED : gra_pkg::ST_OK;
            res_x_r   <= 12'(best_r.x + CW'(pad_r));
            res_y_r   <= 12'(best_r.y + CW'(pad_r));
            if (alloc_r != 16'hFFFF) begin
              alloc_r   <= alloc_r + 16'd1;
              res_tot_r <= alloc_r + 16'd1;
            end else begin
              res_tot_r <= alloc_r;
            end
            state_r <= S_PASS2;
          end
        end
        S_PASS2: begin
          k_r <= k_r + IW'(1);
          if (k_r == IW'(S - 1)) begin
            count_r <= cdel_r + NW'(push1_r) + NW'(push2_r);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_v_r || out_tready) begin
            out_st_r  <= res_st_r;
            out_x_r   <= res_x_r;
            out_y_r   <= res_y_r;
            out_tot_r <= res_tot_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {out_tot_r, out_y_r, out_x_r};

  `GRA_ASSERT(a_count_range, count_r <= NW'(S), "free count beyond slot count")
  `GRA_ASSERT(a_idle_k, (state_r != S_IDLE) || (k_r == '0), "chain counter live while idle")
  `GRA_ASSERT_NEXT(a_nofit_pos, out_v_r && out_st_r == gra_pkg::ST_NOFIT,
    !out_v_r || out_st_r != gra_pkg::ST_NOFIT || (out_x_r == '0 && out_y_r == '0),
    "no-fit result with position")

endmodule

>>> rtl/gra_cell.sv
module gra_cell (
  input  logic              clk,
  input  gra_pkg::cell_ctl_t ctl,
  input  gra_pkg::rect_t    shift_in,
  input  gra_pkg::rect_t    load_val,
  output gra_pkg::rect_t    q
);

  gra_pkg::rect_t data_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= load_val;
    end else if (ctl.shift) begin
      data_r <= shift_in;
    end
  end

  assign q = data_r;

endmodule

>>> rtl/gra_align.sv
module gra_align (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gra_pkg::SIZE_W-1:0]   size_in,
  input  logic [gra_pkg::ALIGN_W-1:0]  align_in,
  output logic                         done,
  output logic [gra_pkg::SIZE_W-1:0]   size_out
);

  localparam int SW   = gra_pkg::SIZE_W;
  localparam int AW   = gra_pkg::ALIGN_W;
  localparam int CW   = $clog2(SW + 1);
  localparam int PW   = SW + AW;

  typedef enum logic [1:0] {A_IDLE, A_DIV, A_MUL} astate_t;

  astate_t        state_r;
  logic [SW-1:0]  div_r;
  logic [SW-1:0]  quo_r;
  logic [AW-1:0]  rem_r;
  logic [AW-1:0]  den_r;
  logic [CW-1:0]  cnt_r;
  logic           done_r;
  logic [SW-1:0]  res_r;

  logic [AW-1:0]  den_eff;
  logic [SW-1:0]  dividend;
  logic [AW:0]    trial;
  logic [AW:0]    diff;
  logic [PW-1:0]  prod;

  assign den_eff  = (align_in == '0) ? AW'(1) : align_in;
  assign dividend = size_in + SW'(den_eff) - SW'(1);
  assign trial    = {rem_r, div_r[SW-1]};
  assign diff     = trial - {1'b0, den_r};
  assign prod     = PW'(quo_r) * PW'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        A_IDLE: begin
          if (start) begin
            div_r   <= dividend;
            den_r   <= den_eff;
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= CW'(SW);
            state_r <= A_DIV;
          end
        end
        A_DIV: begin
          div_r <= {div_r[SW-2:0], 1'b0};
          if (!diff[AW]) begin
            rem_r <= diff[AW-1:0];
            quo_r <= {quo_r[SW-2:0], 1'b1};
          end else begin
            rem_r <= trial[AW-1:0];
            quo_r <= {quo_r[SW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_r <= A_MUL;
          end
        end
        A_MUL: begin
          res_r   <= prod[SW-1:0];
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign size_out = res_r;

endmodule
